### design/rpfbw_pkg.sv
// shared types and constants of the rotated pixel framebuffer writer
package rpfbw_pkg;

  localparam int COORD_W = 12;
  localparam int ADDR_W  = 23;
  localparam int CFG_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE = 1'd1;

  localparam logic [1:0] ROT_NONE  = 2'd0;
  localparam logic [1:0] ROT_LEFT  = 2'd1;
  localparam logic [1:0] ROT_FLIP  = 2'd2;
  localparam logic [1:0] ROT_RIGHT = 2'd3;

  localparam logic STORE_MONO = 1'b0;
  localparam logic STORE_GRAY = 1'b1;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [2:0]         pixel_color;
  } in_item_t;

  typedef struct packed {
    logic        target_store;
    logic [17:0] byte_address;
    logic [7:0]  byte_written;
  } out_item_t;

  // one classified write waiting for the store
  typedef struct packed {
    logic              store;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        sel;
    logic [2:0]        color;
  } wr_cmd_t;

endpackage

### design/rpfbw_front.sv
// front end: configuration, bounds check, rotation and address calculation
module rpfbw_front
  import rpfbw_pkg::*;
#(
  parameter int PANEL_WIDTH  = 800,
  parameter int PANEL_HEIGHT = 600
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 busy_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output wr_cmd_t              cmd_o
);

  localparam logic [15:0] W16 = 16'(PANEL_WIDTH);
  localparam logic [15:0] H16 = 16'(PANEL_HEIGHT);
  localparam logic [COORD_W-1:0] MONO_STRIDE = COORD_W'((PANEL_WIDTH + 7) / 8);
  localparam logic [COORD_W-1:0] GRAY_STRIDE = COORD_W'((PANEL_WIDTH + 1) / 2);

  logic [1:0] rot_q;
  logic       gray_q;

  logic               stg_v_q, stg_v_d;
  logic [COORD_W-1:0] px_q, py_q;
  logic [2:0]         color_q;
  logic               store_q;

  logic [15:0]        ux, uy, lw, lh, tx, ty;
  logic               in_bounds, accept, push;
  logic [COORD_W-1:0] px_d, py_d, stride;
  logic [2*COORD_W-1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q  <= ROT_NONE;
      gray_q <= STORE_MONO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROTATION:  rot_q  <= cfg_data_i;
        CFG_GRAY_MODE: gray_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ux = in_item_i.pos_x;
  assign uy = in_item_i.pos_y;
  assign lw = rot_q[0] ? H16 : W16;
  assign lh = rot_q[0] ? W16 : H16;
  assign in_bounds = !ux[15] && !uy[15] && (ux < lw) && (uy < lh);

  always_comb begin
    tx = ux;
    ty = uy;
    case (rot_q)
      ROT_LEFT: begin
        tx = W16 - 16'd1 - uy;
        ty = ux;
      end
      ROT_FLIP: begin
        tx = W16 - 16'd1 - ux;
        ty = H16 - 16'd1 - uy;
      end
      ROT_RIGHT: begin
        tx = uy;
        ty = H16 - 16'd1 - ux;
      end
      default: begin
        tx = ux;
        ty = uy;
      end
    endcase
  end

  assign px_d = tx[COORD_W-1:0];
  assign py_d = ty[COORD_W-1:0];

  assign push       = stg_v_q && cmd_ready_i;
  assign in_stall_o = busy_i || (stg_v_q && !cmd_ready_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    stg_v_d = stg_v_q;
    if (accept) begin
      stg_v_d = in_bounds;
    end else if (push) begin
      stg_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= px_d;
      py_q    <= py_d;
      color_q <= in_item_i.pixel_color;
      store_q <= gray_q;
    end
  end

  assign stride = store_q ? GRAY_STRIDE : MONO_STRIDE;
  assign prod   = py_q * stride;

  always_comb begin
    cmd_o.store = store_q;
    cmd_o.color = color_q;
    if (store_q) begin
      cmd_o.addr = ADDR_W'(prod) + ADDR_W'(px_q >> 1);
      cmd_o.sel  = {2'b00, px_q[0]};
    end else begin
      cmd_o.addr = ADDR_W'(prod) + ADDR_W'(px_q >> 3);
      cmd_o.sel  = px_q[2:0];
    end
  end

  assign cmd_valid_o = stg_v_q;

endmodule

### design/rpfbw_queue.sv
// two-entry queue of write commands between front and back end
module rpfbw_queue
  import rpfbw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  wr_cmd_t push_cmd_i,
  output logic    pop_valid_o,
  input  logic    pop_i,
  output wr_cmd_t pop_cmd_o
);

  wr_cmd_t    slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_cmd_o    = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

### design/rpfbw_back.sv
// back end: frame stores, clearing pass and read-modify-write of one byte
module rpfbw_back
  import rpfbw_pkg::*;
#(
  parameter int PANEL_WIDTH  = 800,
  parameter int PANEL_HEIGHT = 600
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  output logic      busy_o,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  wr_cmd_t   cmd_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int MONO_DEPTH = ((PANEL_WIDTH + 7) / 8) * PANEL_HEIGHT;
  localparam int GRAY_DEPTH = ((PANEL_WIDTH + 1) / 2) * PANEL_HEIGHT;
  localparam int MAW = (MONO_DEPTH > 1) ? $clog2(MONO_DEPTH) : 1;
  localparam int GAW = (GRAY_DEPTH > 1) ? $clog2(GRAY_DEPTH) : 1;

  localparam logic [1:0] BK_CLEAR = 2'd0;
  localparam logic [1:0] BK_IDLE  = 2'd1;
  localparam logic [1:0] BK_MOD   = 2'd2;

  logic [7:0] mono_mem [MONO_DEPTH];
  logic [7:0] gray_mem [GRAY_DEPTH];

  logic [1:0]     state_q, state_d;
  logic [GAW-1:0] clr_q;
  wr_cmd_t        cur_q;
  logic [7:0]     rd_mono_q, rd_gray_q;
  logic           out_v_q;
  out_item_t      out_q;

  logic           out_free, finish;
  logic [7:0]     mask, new_byte;
  logic           mono_we, gray_we;
  logic [MAW-1:0] mono_waddr;
  logic [GAW-1:0] gray_waddr;
  logic [7:0]     mono_wdata, gray_wdata;

  assign busy_o    = (state_q == BK_CLEAR);
  assign cmd_pop_o = (state_q == BK_IDLE) && cmd_valid_i;
  assign out_free  = !out_v_q || !out_stall_i;
  assign finish    = (state_q == BK_MOD) && out_free;

  // merge the pixel into the byte just read
  always_comb begin
    mask = 8'd1 << cur_q.sel;
    if (cur_q.store == STORE_GRAY) begin
      if (cur_q.sel[0]) begin
        new_byte = {rd_gray_q[7:4], 1'b0, cur_q.color};
      end else begin
        new_byte = {1'b0, cur_q.color, rd_gray_q[3:0]};
      end
    end else begin
      new_byte = (rd_mono_q & ~mask) | ((cur_q.color != 3'd0) ? mask : 8'd0);
    end
  end

  always_comb begin
    mono_we    = 1'b0;
    gray_we    = 1'b0;
    mono_waddr = cur_q.addr[MAW-1:0];
    gray_waddr = cur_q.addr[GAW-1:0];
    mono_wdata = new_byte;
    gray_wdata = new_byte;
    if (state_q == BK_CLEAR) begin
      mono_we    = (GAW'(clr_q) < GAW'(MONO_DEPTH));
      gray_we    = 1'b1;
      mono_waddr = clr_q[MAW-1:0];
      gray_waddr = clr_q;
      mono_wdata = 8'h00;
      gray_wdata = 8'hff;
    end else if (finish) begin
      mono_we = (cur_q.store == STORE_MONO);
      gray_we = (cur_q.store == STORE_GRAY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mono_we) begin
      mono_mem[mono_waddr] <= mono_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gray_we) begin
      gray_mem[gray_waddr] <= gray_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      rd_mono_q <= mono_mem[cmd_i.addr[MAW-1:0]];
      rd_gray_q <= gray_mem[cmd_i.addr[GAW-1:0]];
      cur_q     <= cmd_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: begin
        if (clr_q == GAW'(GRAY_DEPTH - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = BK_MOD;
        end
      end
      BK_MOD: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) begin
        clr_q <= clr_q + GAW'(1);
      end
      if (finish) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q.target_store <= cur_q.store;
      out_q.byte_address <= 18'(cur_q.addr);
      out_q.byte_written <= new_byte;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

### design/rotated_pixel_framebuffer_writer_unit.sv
// top level of the rotated pixel framebuffer writer
// an accepted item passes the stage register, the queue, the store read and the merge before its result
// the back end takes a new command only after writing the last one back, as each reads then writes the frame store
// out-of-bounds items are accepted and give no result
// after reset a clearing pass over the GRAY_DEPTH addresses (240000 at 800 x 600) fills both stores
// with their reset bytes; no item is accepted until it ends, configuration writes are taken
module rotated_pixel_framebuffer_writer_unit
  import rpfbw_pkg::*;
#(
  parameter int PANEL_WIDTH  = 800,
  parameter int PANEL_HEIGHT = 600
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  logic    busy;
  logic    f_valid, f_ready;
  wr_cmd_t f_cmd;
  logic    b_valid, b_pop;
  wr_cmd_t b_cmd;

  rpfbw_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_i     (busy),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  rpfbw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_cmd_i  (f_cmd),
    .pop_valid_o (b_valid),
    .pop_i       (b_pop),
    .pop_cmd_o   (b_cmd)
  );

  rpfbw_back #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (busy),
    .cmd_valid_i(b_valid),
    .cmd_pop_o  (b_pop),
    .cmd_i      (b_cmd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
